FILE: rtl/bqlp_pkg.sv
// Package for the stereo biquad low-pass: widths, fixed-point formats,
// register indexes and the coefficient set type. No dependencies.
`default_nettype none

package bqlp_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int COEF_W         = 32;
    localparam int COEF_FRAC_BITS = 30;
    localparam int HIST_FRAC_BITS = 16;
    // Q18.16 output history
    localparam int HIST_W         = 18 + HIST_FRAC_BITS;
    // x0 + 2*x1 + x2 needs two extra bits plus sign headroom
    localparam int SUMX_W         = SAMPLE_W + 3;
    localparam int ACC_W          = COEF_W + HIST_W + 4;
    localparam int SHR_W          = ACC_W - COEF_FRAC_BITS;
    localparam int YINT_W         = HIST_W - HIST_FRAC_BITS;

    localparam int CFG_IDX_W      = 2;
    localparam logic [CFG_IDX_W-1:0] REG_FF_GAIN  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FB_FIRST = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_FB_SECOND = CFG_IDX_W'(2);

    typedef struct packed {
        logic signed [COEF_W-1:0] ff_gain;
        logic signed [COEF_W-1:0] fb_first;
        logic signed [COEF_W-1:0] fb_second;
    } t_coefs;

endpackage

`default_nettype wire

FILE: rtl/bqlp_cfg_regs.sv
// Coefficient register file for the biquad (a0, b1, b2 in Q2.30).
// Depends on bqlp_pkg.
`default_nettype none

module bqlp_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [bqlp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [bqlp_pkg::COEF_W-1:0]    i_cfg_wdata,
    output bqlp_pkg::t_coefs                    o_coefs
);
    import bqlp_pkg::*;

    t_coefs r_coefs;
    t_coefs n_coefs;

    always_comb begin
        n_coefs = r_coefs;
        if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_FF_GAIN:   n_coefs.ff_gain   = i_cfg_wdata;
                REG_FB_FIRST:  n_coefs.fb_first  = i_cfg_wdata;
                REG_FB_SECOND: n_coefs.fb_second = i_cfg_wdata;
                default:       n_coefs = r_coefs;  // unmapped index ignored
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs <= '0;
        end else begin
            r_coefs <= n_coefs;
        end
    end

    assign o_coefs = r_coefs;

endmodule

`default_nettype wire

FILE: rtl/bqlp_channel.sv
// One channel of the direct form I biquad: input/output history registers
// and the combinational multiply-accumulate, scaling and saturation.
// Depends on bqlp_pkg.
`default_nettype none

module bqlp_channel (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_step,
    input  wire logic signed [bqlp_pkg::SAMPLE_W-1:0] i_sample,
    input  wire bqlp_pkg::t_coefs                    i_coefs,
    output logic signed [bqlp_pkg::SAMPLE_W-1:0]     o_filtered
);
    import bqlp_pkg::*;

    logic signed [SAMPLE_W-1:0]          r_in1, r_in2;
    logic signed [HIST_W-1:0]            r_out1, r_out2;

    logic signed [SUMX_W-1:0]            sumx;
    logic signed [COEF_W+SUMX_W-1:0]     ff_prod;
    logic signed [COEF_W+HIST_W-1:0]     fb1_prod, fb2_prod;
    logic signed [ACC_W-1:0]             acc;
    logic signed [SHR_W-1:0]             shr;
    logic signed [HIST_W-1:0]            n_out1;
    logic signed [YINT_W-1:0]            y_int;
    logic signed [YINT_W-1:0]            y_trunc;

    always_comb begin
        sumx     = SUMX_W'(i_sample) + (SUMX_W'(r_in1) <<< 1) + SUMX_W'(r_in2);
        ff_prod  = i_coefs.ff_gain * sumx;
        fb1_prod = i_coefs.fb_first * r_out1;
        fb2_prod = i_coefs.fb_second * r_out2;
        acc      = (ACC_W'(ff_prod) <<< HIST_FRAC_BITS)
                 - ACC_W'(fb1_prod) - ACC_W'(fb2_prod);
        // floor shift into the history format
        shr      = SHR_W'(acc >>> COEF_FRAC_BITS);

        // saturate to the history range: the dropped top bits must match the sign
        if (shr[SHR_W-1:HIST_W-1] == '0 || shr[SHR_W-1:HIST_W-1] == '1) begin
            n_out1 = shr[HIST_W-1:0];
        end else if (shr[SHR_W-1]) begin
            n_out1 = {1'b1, {(HIST_W-1){1'b0}}};
        end else begin
            n_out1 = {1'b0, {(HIST_W-1){1'b1}}};
        end

        // integer part, truncated toward zero
        y_int = n_out1[HIST_W-1:HIST_FRAC_BITS];
        if (n_out1[HIST_W-1] && (n_out1[HIST_FRAC_BITS-1:0] != '0)) begin
            y_trunc = y_int + YINT_W'(1);
        end else begin
            y_trunc = y_int;
        end

        if (y_trunc[YINT_W-1:SAMPLE_W-1] == '0 || y_trunc[YINT_W-1:SAMPLE_W-1] == '1) begin
            o_filtered = y_trunc[SAMPLE_W-1:0];
        end else if (y_trunc[YINT_W-1]) begin
            o_filtered = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            o_filtered = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in1  <= '0;
            r_in2  <= '0;
            r_out1 <= '0;
            r_out2 <= '0;
        end else if (i_step) begin
            r_in1  <= i_sample;
            r_in2  <= r_in1;
            r_out1 <= n_out1;
            r_out2 <= r_out1;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/stereo_biquad_lowpass.sv
// Top level of the stereo Butterworth biquad low-pass (direct form I).
// Depends on bqlp_pkg, bqlp_cfg_regs and bqlp_channel.
//
//   channel   direction  signals                                     payload
//   input     in         i_in_valid / o_in_stall                     left/right sample
//   output    out        o_out_valid / i_out_stall                   left/right filtered
//   config    in         i_cfg_wr_en, i_cfg_index, i_cfg_wdata       32-bit coefficient
//
// One sample pair per cycle sustained while the output is not stalled. The
// filter recursion is combinational: the three products, the sum and
// saturation sit between the input register and the result register.
// Reset (synchronous, active low) clears coefficients, history and valids.
// A stall on the output holds the result; the input register keeps taking
// transfers as long as the result register can move.
`default_nettype none

module stereo_biquad_lowpass (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_stall,
    input  wire logic signed [bqlp_pkg::SAMPLE_W-1:0] i_left_sample,
    input  wire logic signed [bqlp_pkg::SAMPLE_W-1:0] i_right_sample,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_stall,
    output logic signed [bqlp_pkg::SAMPLE_W-1:0]      o_left_filtered,
    output logic signed [bqlp_pkg::SAMPLE_W-1:0]      o_right_filtered,
    input  wire logic                                 i_cfg_wr_en,
    input  wire logic [bqlp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [bqlp_pkg::COEF_W-1:0]          i_cfg_wdata
);
    import bqlp_pkg::*;

    t_coefs                     coefs;
    logic                       r_in_valid;
    logic signed [SAMPLE_W-1:0] r_left_in, r_right_in;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_left_out, r_right_out;
    logic signed [SAMPLE_W-1:0] left_res, right_res;
    logic                       out_free;
    logic                       step;
    logic                       in_take;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    bqlp_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_coefs     (coefs)
    );

    bqlp_channel u_left (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_sample   (r_left_in),
        .i_coefs    (coefs),
        .o_filtered (left_res)
    );

    bqlp_channel u_right (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_sample   (r_right_in),
        .i_coefs    (coefs),
        .o_filtered (right_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (step) begin
                r_in_valid <= 1'b0;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_left_in  <= i_left_sample;
            r_right_in <= i_right_sample;
        end
        if (step) begin
            r_left_out  <= left_res;
            r_right_out <= right_res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_left_filtered  = r_left_out;
    assign o_right_filtered = r_right_out;

endmodule

`default_nettype wire

FILE: tb/tb_stereo_biquad_lowpass.sv
// Self-checking testbench for stereo_biquad_lowpass: random-gap sample driver,
// stalling result monitor, and a bit-exact fixed-point biquad predictor.
// Depends on bqlp_pkg and the stereo_biquad_lowpass RTL.
`timescale 1ns / 100ps

module tb_stereo_biquad_lowpass;
    import bqlp_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_OFF_CYCLES = 48;
    localparam int DRAIN_CYCLES    = 4;
    // unmapped register index, writes must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);
    localparam logic signed [79:0] HIST_HI = (80'sd1 <<< (HIST_W - 1)) - 80'sd1;
    localparam logic signed [79:0] HIST_LO = -(80'sd1 <<< (HIST_W - 1));
    localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] S_MIN = 16'sh8000;

    typedef struct packed {
        logic [SAMPLE_W-1:0] left;
        logic [SAMPLE_W-1:0] right;
    } t_stereo;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    logic signed [SAMPLE_W-1:0] i_left_sample = '0;
    logic signed [SAMPLE_W-1:0] i_right_sample = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic signed [SAMPLE_W-1:0] o_left_filtered;
    logic signed [SAMPLE_W-1:0] o_right_filtered;
    logic                       i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [COEF_W-1:0]          i_cfg_wdata = '0;

    always #5 i_clk = ~i_clk;

    stereo_biquad_lowpass u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_left_sample    (i_left_sample),
        .i_right_sample   (i_right_sample),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_left_filtered  (o_left_filtered),
        .o_right_filtered (o_right_filtered),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata)
    );

    // predictor state: coefficients and per-channel history (0 = left, 1 = right)
    logic signed [COEF_W-1:0]   coef_ff = '0;
    logic signed [COEF_W-1:0]   coef_fb1 = '0;
    logic signed [COEF_W-1:0]   coef_fb2 = '0;
    logic signed [SAMPLE_W-1:0] x_d1 [2] = '{default: '0};
    logic signed [SAMPLE_W-1:0] x_d2 [2] = '{default: '0};
    logic signed [HIST_W-1:0]   y_d1 [2] = '{default: '0};
    logic signed [HIST_W-1:0]   y_d2 [2] = '{default: '0};

    t_stereo sample_q [$];
    t_stereo filtered_q [$];

    bit drv_busy = 1'b0;
    bit steady = 1'b0;
    int drv_wait = 0;
    int rx_wait = 0;
    int rx_hold = 0;
    int pairs_sent = 0;
    int pairs_checked = 0;
    int mismatches = 0;
    int cfg_writes = 0;
    int coef_sets = 0;
    int idle_cycles = 0;
    int in_stall_cycles = 0;

    // One direct form I step: exact sum, floor into Q18.16, saturate, then
    // truncate toward zero to a saturated 16-bit sample.
    function automatic logic signed [SAMPLE_W-1:0] biquad_step(
        int ch, logic signed [SAMPLE_W-1:0] x0);
        logic signed [79:0]       sum_x;
        logic signed [79:0]       acc;
        logic signed [79:0]       shifted;
        logic signed [HIST_W-1:0] y0;
        longint                   q;
        sum_x = x0 + 2 * x_d1[ch] + x_d2[ch];
        acc = (sum_x <<< HIST_FRAC_BITS) * coef_ff
              - y_d1[ch] * coef_fb1 - y_d2[ch] * coef_fb2;
        shifted = acc >>> COEF_FRAC_BITS;
        if (shifted > HIST_HI)
            y0 = HIST_HI[HIST_W-1:0];
        else if (shifted < HIST_LO)
            y0 = HIST_LO[HIST_W-1:0];
        else
            y0 = shifted[HIST_W-1:0];
        x_d2[ch] = x_d1[ch];
        x_d1[ch] = x0;
        y_d2[ch] = y_d1[ch];
        y_d1[ch] = y0;
        q = longint'(y0) / (longint'(1) <<< HIST_FRAC_BITS);
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return SAMPLE_W'(q);
    endfunction

    function automatic int draw_wait();
        if (steady || $urandom_range(0, 3) == 0)
            return 0;
        return int'($urandom_range(0, 8));
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return S_MAX;
            1: return S_MIN;
            2: return SAMPLE_W'($urandom_range(0, 4) - 2);
            3: return SAMPLE_W'($urandom_range(0, 128) - 64);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic flag_error(string msg);
        if (mismatches < 10)
            $display("[%0t] ERROR: %s", $realtime, msg);
        mismatches++;
    endtask

    // Sample driver: predicts on every accepted transfer, then draws a gap
    always @(posedge i_clk) begin
        t_stereo nxt;
        t_stereo want;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            drv_busy = 1'b0;
            drv_wait = 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                want.left = biquad_step(0, i_left_sample);
                want.right = biquad_step(1, i_right_sample);
                filtered_q.push_back(want);
                pairs_sent++;
                drv_busy = 1'b0;
                drv_wait = draw_wait();
            end
            if (!drv_busy) begin
                if (drv_wait > 0) begin
                    drv_wait--;
                end else if (sample_q.size() > 0) begin
                    nxt = sample_q.pop_front();
                    i_left_sample <= nxt.left;
                    i_right_sample <= nxt.right;
                    drv_busy = 1'b1;
                end
            end
            i_in_valid <= drv_busy;
        end
    end

    // Result monitor: compares against the oldest prediction, stalls at random
    always @(posedge i_clk) begin
        t_stereo want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            rx_wait = 0;
            rx_hold = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (filtered_q.size() == 0) begin
                    flag_error($sformatf("unexpected result L=%0d R=%0d",
                                         o_left_filtered, o_right_filtered));
                end else begin
                    want = filtered_q.pop_front();
                    if (o_left_filtered !== want.left)
                        flag_error($sformatf("left: expected %0d, got %0d",
                                             $signed(want.left), o_left_filtered));
                    if (o_right_filtered !== want.right)
                        flag_error($sformatf("right: expected %0d, got %0d",
                                             $signed(want.right), o_right_filtered));
                end
                pairs_checked++;
                // long hold-off so the pipeline fills and backs up the input
                if (pairs_checked == 200 || pairs_checked == 450)
                    rx_hold = HOLD_OFF_CYCLES;
                rx_wait = draw_wait();
            end
            if (rx_hold > 0) begin
                rx_hold--;
                i_out_stall <= 1'b1;
            end else if (rx_wait > 0) begin
                rx_wait--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_in_valid && o_in_stall)
            in_stall_cycles++;
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_wr_en) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
                         idle_cycles, filtered_q.size());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            REG_FF_GAIN:   coef_ff = val;
            REG_FB_FIRST:  coef_fb1 = val;
            REG_FB_SECOND: coef_fb2 = val;
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic load_coefs(logic [COEF_W-1:0] ff, logic [COEF_W-1:0] fb1,
                              logic [COEF_W-1:0] fb2);
        cfg_write(REG_FF_GAIN, ff);
        cfg_write(REG_FB_FIRST, fb1);
        cfg_write(REG_FB_SECOND, fb2);
        coef_sets++;
    endtask

    task automatic queue_pair(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r);
        t_stereo p;
        p.left = l;
        p.right = r;
        sample_q.push_back(p);
    endtask

    // Half smooth random-walk audio, half arbitrary samples
    task automatic queue_random(int n);
        int walk_l;
        int walk_r;
        walk_l = 0;
        walk_r = 0;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 1) == 1) begin
                walk_l += int'($urandom_range(0, 8000)) - 4000;
                walk_r += int'($urandom_range(0, 8000)) - 4000;
                if (walk_l > 32767) walk_l = 32767;
                if (walk_l < -32768) walk_l = -32768;
                if (walk_r > 32767) walk_r = 32767;
                if (walk_r < -32768) walk_r = -32768;
                queue_pair(SAMPLE_W'(walk_l), SAMPLE_W'(walk_r));
            end else begin
                queue_pair(rand_sample(), rand_sample());
            end
        end
    endtask

    // Block is idle once the driver is empty and every prediction is matched
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (sample_q.size() != 0 || drv_busy || filtered_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset coefficients: everything filters to zero
        queue_pair(S_MAX, S_MIN);
        queue_pair(-16'sd1, 16'sd1);
        queue_pair(16'sh5555, 16'shAAAA);
        wait_drained();

        // unity gain: x0 + 2*x1 + x2 overflows the output range
        load_coefs(32'h4000_0000, 32'h0000_0000, 32'h0000_0000);
        repeat (3) queue_pair(S_MAX, S_MIN);
        queue_pair(16'sd0, 16'sd0);
        queue_pair(S_MIN, S_MAX);
        wait_drained();

        // quarter gain: negative fractions must truncate toward zero
        cfg_write(REG_FF_GAIN, 32'h1000_0000);
        queue_pair(-16'sd1, 16'sd1);
        queue_pair(-16'sd2, 16'sd3);
        queue_pair(-16'sd3, -16'sd5);
        queue_pair(16'sd1, -16'sd1);
        wait_drained();

        // smallest gain: history floors to -1 LSB, output stays 0;
        // the unmapped index must not disturb anything
        cfg_write(REG_FF_GAIN, 32'h0000_0001);
        cfg_write(REG_SPARE, 32'hFFFF_FFFF);
        queue_pair(-16'sd1, 16'sd1);
        queue_pair(S_MIN, S_MAX);
        queue_pair(S_MIN, S_MAX);
        wait_drained();

        // extreme, unstable coefficients drive the history into saturation
        load_coefs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_pair(S_MAX, S_MIN);
        queue_pair(S_MIN, S_MAX);
        queue_pair(16'sd0, 16'sd0);
        queue_pair(16'sd1, -16'sd1);
        wait_drained();
        load_coefs(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_pair(S_MAX, S_MAX);
        queue_pair(S_MIN, S_MIN);
        queue_pair(16'sd100, -16'sd100);
        wait_drained();

        // Butterworth, cutoff 0.1 fs
        load_coefs(32'd72_430_000, -32'sd1_227_400_000, 32'd443_260_000);
        queue_random(128);
        wait_drained();

        // Butterworth, cutoff 0.02 fs, no random gaps on either side
        steady = 1'b1;
        load_coefs(32'd3_888_860, -32'sd1_957_100_000, 32'd898_920_000);
        queue_random(128);
        wait_drained();
        steady = 1'b0;

        // fixed coefficient set with positive feedback terms
        load_coefs(32'd499_450_000, 32'd1_300_310_000, 32'd482_730_000);
        queue_random(128);
        wait_drained();

        // moderate random gain with random feedback
        load_coefs($urandom_range(0, 32'h1000_0000), $urandom, $urandom_range(0, 32'h3000_0000));
        queue_random(128);
        wait_drained();

        // fully random coefficients
        load_coefs($urandom, $urandom, $urandom);
        queue_random(128);
        wait_drained();

        repeat (10) @(negedge i_clk);
        if (filtered_q.size() != 0)
            flag_error($sformatf("%0d results never arrived", filtered_q.size()));

        $display("Summary: %0d sample pairs over %0d coefficient sets, %0d register writes,",
                 pairs_sent, coef_sets, cfg_writes);
        $display("         %0d results checked, input back-pressured %0d cycles, %0d errors.",
                 pairs_checked, in_stall_cycles, mismatches);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/bqlp_pkg.sv
rtl/bqlp_cfg_regs.sv
rtl/bqlp_channel.sv
rtl/stereo_biquad_lowpass.sv
tb/tb_stereo_biquad_lowpass.sv
